// File: sv/eta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eta_pkg
// Shared constants for the energy threshold adapter.
// ----------------------------------------------------------------------------
package eta_pkg;
  localparam int NUM_TASKS     = 8;
  localparam int HISTORY_DEPTH = 8;
  localparam int TASK_W        = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int POS_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W         = 16 + POS_W + 1;
  localparam int ADDR_W        = 3;

  localparam logic [ADDR_W-1:0] REG_MIN_TICKS = 3'd0;
  localparam logic [ADDR_W-1:0] REG_MAX_DROP  = 3'd1;
  localparam logic [ADDR_W-1:0] REG_STEP_DIV  = 3'd2;
  localparam logic [ADDR_W-1:0] REG_TH_LIMIT  = 3'd3;
  localparam logic [ADDR_W-1:0] REG_INIT_TH   = 3'd4;

  localparam logic [7:0] FAIL_BUMP = 8'd2;
endpackage
`default_nettype wire

// File: sv/energy_threshold_adapter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// energy_threshold_adapter_core
// Per-task supply threshold keeper with drop profiling and ring averaging.
// ----------------------------------------------------------------------------
// channel | handshake             | payload
// in_     | start, busy           | action, func_id, comparator, timers, ADC
// out_    | out_valid (strobe)    | threshold_index, exe_drop, two flags
// cfg_    | psel/penable/pwrite   | five registers at 4*i
//
// A start item, an unprofiled end item or an ignored task keeps busy high
// through the decide and done states; the result strobe follows in the next
// cycle. A profiled end item runs the 32-bit divide t2*256/t1 one quotient bit
// a cycle, then a multiply and the drop estimate. When the ring fills, the ring
// sum (one entry a cycle) and the divide by the step register through the same
// restoring divider follow. Synchronous active-low reset loads thresholds from
// the reset value of initial_threshold.
// The receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module energy_threshold_adapter_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [2:0]  in_func_id,
  input  wire logic        in_end_comparator_high,
  input  wire logic [15:0] in_charge_ticks,
  input  wire logic [15:0] in_end_timer,
  input  wire logic [11:0] in_v_before_charge,
  input  wire logic [11:0] in_v_after_charge,
  input  wire logic [11:0] in_v_after_exe,
  output logic             out_valid,
  output logic [7:0]       out_threshold_index,
  output logic [15:0]      out_exe_drop,
  output logic             out_sample_stored,
  output logic             out_threshold_adapted,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [eta_pkg::ADDR_W+1:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import eta_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_DECIDE = 4'd1, S_DIV = 4'd2,
                         S_MUL = 4'd3, S_EST = 4'd4, S_SUM = 4'd5,
                         S_MEAN = 4'd6, S_DIV2 = 4'd7, S_CLAMP = 4'd8,
                         S_DONE = 4'd9;

  // config registers
  logic [15:0] min_ticks_r;
  logic [16:0] max_drop_r;
  logic [11:0] step_div_r;
  logic [7:0]  th_limit_r, init_th_r;
  logic [ADDR_W-1:0] reg_idx;
  logic cfg_wr;
  assign reg_idx = paddr[ADDR_W+1:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ticks_r <= 16'd100;
      max_drop_r  <= 17'd4096;
      step_div_r  <= 12'd32;
      th_limit_r  <= 8'd32;
      init_th_r   <= 8'd10;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MIN_TICKS: min_ticks_r <= pwdata[15:0];
        REG_MAX_DROP:  max_drop_r  <= pwdata[16:0];
        REG_STEP_DIV:  step_div_r  <= pwdata[11:0];
        REG_TH_LIMIT:  th_limit_r  <= pwdata[7:0];
        REG_INIT_TH:   init_th_r   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_TICKS: prdata = {16'd0, min_ticks_r};
      REG_MAX_DROP:  prdata = {15'd0, max_drop_r};
      REG_STEP_DIV:  prdata = {20'd0, step_div_r};
      REG_TH_LIMIT:  prdata = {24'd0, th_limit_r};
      REG_INIT_TH:   prdata = {24'd0, init_th_r};
      default:       prdata = 32'd0;
    endcase
  end

  // per-task state
  logic             fail_r [NUM_TASKS];
  logic [7:0]       th_r   [NUM_TASKS];
  logic [POS_W-1:0] pos_r  [NUM_TASKS];
  logic [15:0]      hist_mem [NUM_TASKS*HISTORY_DEPTH];

  // item latch
  logic [3:0]  state_r;
  logic        act_r, cmp_r, valid_task_r;
  logic [TASK_W-1:0] task_r;
  logic [15:0] t1_r, tend_r;
  logic [11:0] vb_r, va_r, ve_r;

  // shared divider: rem/quot, 32 steps
  logic [31:0] quo_r, divisor_r;
  logic [32:0] rem_r;
  logic [5:0]  cnt_r;
  logic [31:0] acc_r;
  logic [15:0] drop_r;
  logic [SUM_W-1:0] sum_r;
  logic [15:0] hrd_r;
  logic [POS_W:0] scnt_r;
  logic        stored_r, adapted_r;

  logic [32:0] rem_sh;
  logic [32:0] rem_sub;
  assign rem_sh  = {rem_r[31:0], quo_r[31]};
  assign rem_sub = rem_sh - {1'b0, divisor_r};

  logic [TASK_W-1:0] in_task;
  assign in_task = in_func_id[TASK_W-1:0];
  logic [31:0] dvc, dvd, t2;
  assign t2  = {16'd0, tend_r} - {16'd0, t1_r};
  assign dvc = {20'd0, va_r} - {20'd0, vb_r};
  assign dvd = {20'd0, va_r} - {20'd0, ve_r};

  // drop = (q*dvc + dvd*256) / 256, low 16 bits, all modulo 2^32
  logic [31:0] est_sum;
  logic [15:0] est_drop;
  logic        keep_drop;
  assign est_sum   = acc_r + {dvd[23:0], 8'd0};
  assign est_drop  = est_sum[23:8];
  assign keep_drop = ({1'b0, est_drop} < max_drop_r);

  logic [$clog2(NUM_TASKS*HISTORY_DEPTH)-1:0] hist_wa, hist_ra;
  assign hist_wa = ($bits(hist_wa))'({task_r, pos_r[task_r]});
  assign hist_ra = ($bits(hist_ra))'({task_r, scnt_r[POS_W-1:0]});

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (state_r == S_EST && stored_r) hist_mem[hist_wa] <= drop_r;
    hrd_r <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        fail_r[i] <= 1'b0;
        th_r[i]   <= 8'd10;
        pos_r[i]  <= '0;
      end
    end else begin
      // strobe for exactly the cycle after the done state
      out_valid <= (state_r == S_DONE);
      unique case (state_r)
        S_IDLE: if (start) begin
          act_r <= in_action; cmp_r <= in_end_comparator_high;
          task_r <= in_task;
          valid_task_r <= ({29'd0, in_func_id} < 32'(NUM_TASKS));
          t1_r <= in_charge_ticks; tend_r <= in_end_timer;
          vb_r <= in_v_before_charge; va_r <= in_v_after_charge;
          ve_r <= in_v_after_exe;
          stored_r <= 1'b0; adapted_r <= 1'b0; drop_r <= 16'd0;
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!valid_task_r) begin
            state_r <= S_DONE;
          end else if (!act_r) begin
            if (fail_r[task_r]) th_r[task_r] <= th_r[task_r] + FAIL_BUMP;
            fail_r[task_r] <= 1'b1;
            state_r <= S_DONE;
          end else begin
            fail_r[task_r] <= 1'b0;
            if (!cmp_r) th_r[task_r] <= th_r[task_r] + FAIL_BUMP;
            if (t1_r > min_ticks_r) begin
              // t1 is non-zero here since it exceeds an unsigned minimum
              quo_r <= {t2[23:0], 8'd0}; rem_r <= '0;
              divisor_r <= {16'd0, t1_r}; cnt_r <= '0;
              state_r <= S_DIV;
            end else state_r <= S_DONE;
          end
        end
        S_DIV, S_DIV2: begin
          if (!rem_sub[32]) begin
            rem_r <= rem_sub; quo_r <= {quo_r[30:0], 1'b1};
          end else begin
            rem_r <= rem_sh;  quo_r <= {quo_r[30:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd31) state_r <= (state_r == S_DIV) ? S_MUL : S_CLAMP;
        end
        S_MUL: begin
          acc_r <= quo_r * dvc;
          state_r <= S_EST;
          drop_r <= 16'd0;
        end
        S_EST: begin
          if (!stored_r) begin
            // first pass: form the drop and decide on storage
            drop_r   <= est_drop;
            stored_r <= keep_drop;
            state_r  <= keep_drop ? S_EST : S_DONE;
          end else begin
            // memory written this cycle; advance ring position
            if (32'(pos_r[task_r]) == HISTORY_DEPTH - 1) begin
              pos_r[task_r] <= '0;
              sum_r <= '0; scnt_r <= '0;
              state_r <= S_SUM;
            end else begin
              pos_r[task_r] <= pos_r[task_r] + 1'b1;
              state_r <= S_DONE;
            end
          end
        end
        S_SUM: begin
          // registered memory read: accumulate the previous read
          if (scnt_r != '0) sum_r <= sum_r + SUM_W'(hrd_r);
          scnt_r <= scnt_r + 1'b1;
          if (32'(scnt_r) == HISTORY_DEPTH) state_r <= S_MEAN;
        end
        S_MEAN: begin
          quo_r <= 32'(sum_r / HISTORY_DEPTH); rem_r <= '0;
          divisor_r <= {20'd0, step_div_r}; cnt_r <= '0;
          state_r <= S_DIV2;
        end
        S_CLAMP: begin
          // all-ones quotient for a zero step falls out of the divider
          if (quo_r[7:0] >= th_limit_r) th_r[task_r] <= th_limit_r - 8'd1;
          else th_r[task_r] <= quo_r[7:0];
          adapted_r <= 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_threshold_index   <= valid_task_r ? th_r[task_r] : 8'd0;
          out_exe_drop          <= drop_r;
          out_sample_stored     <= stored_r;
          out_threshold_adapted <= adapted_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: sv/eta_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eta_props
// Port-level checks for the threshold adapter.
// ----------------------------------------------------------------------------
module eta_props (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic out_sample_stored,
  input wire logic out_threshold_adapted,
  input wire logic pready
);
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy not raised");
  a_strobe_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  a_adapt_stored: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_threshold_adapted) |-> out_sample_stored)
    else $error("adapt without store");
  a_ready: assert property (@(posedge clk) pready) else $error("pready low");
endmodule

bind energy_threshold_adapter_core eta_props u_eta_props (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid),
  .out_sample_stored(out_sample_stored),
  .out_threshold_adapted(out_threshold_adapted),
  .pready(pready));
`default_nettype wire
